>>> rtl/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the servo slew ramp
// Request and result payloads, classified command, config register map and
// the step-size helper used by the ramp engine.
// ----------------------------------------------------------------------------
package ssr_pkg;

    // Geometry and fixed values of the ramp
    localparam int NUM_LOCATIONS_DEF = 8;
    localparam int QUEUE_DEPTH       = 2;
    localparam int WIDTH_W           = 12;
    localparam int STEP_W            = 4;
    localparam int INTERVAL_W        = 8;
    localparam int LOC_W             = 3;
    localparam int SSTEP_W           = 5;

    localparam logic [WIDTH_W-1:0] HOME_LOW     = 12'd900;
    localparam logic [WIDTH_W-1:0] HOME_HIGH    = 12'd2100;
    localparam logic [WIDTH_W-1:0] HOME_DEFAULT = 12'd1500;
    localparam logic [WIDTH_W-1:0] DEADBAND     = 12'd8;
    localparam logic [STEP_W-1:0]  STEP_MIN     = 4'd2;
    localparam logic [STEP_W-1:0]  STEP_MAX     = 4'd12;
    localparam logic [STEP_W-1:0]  STEP_FALLBACK = 4'd5;

    localparam logic [STEP_W-1:0]     STEP_RESET     = 4'd5;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd4;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic CFG_STEP_SIZE     = 1'b0;
    localparam logic CFG_TICK_INTERVAL = 1'b1;

    // Request codes as they arrive on the input channel
    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_GO_LOC   = 3'd1,
        REQ_GO_WIDTH = 3'd2,
        REQ_SAVE     = 3'd3,
        REQ_WRITE    = 3'd4,
        REQ_HOME     = 3'd5
    } req_code_t;

    // Classified operations handed to the ramp engine
    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_TICK     = 3'd1,
        OP_GO_LOC   = 3'd2,
        OP_GO_WIDTH = 3'd3,
        OP_SAVE     = 3'd4,
        OP_WRITE    = 3'd5,
        OP_HOME     = 3'd6
    } op_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [LOC_W-1:0]   loc_index;
        logic [WIDTH_W-1:0] width_value;
    } req_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] drive_width;
        logic [WIDTH_W-1:0] settled_position;
        logic               moving;
        logic               refused;
    } rsp_t;

    typedef struct packed {
        op_t                op;
        logic [LOC_W-1:0]   loc;
        logic [WIDTH_W-1:0] width;
    } cmd_t;

    // Map an out-of-range step size to the fallback
    function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] r;
        r = s;
        if (s < STEP_MIN || s > STEP_MAX)
        begin
            r = STEP_FALLBACK;
        end
        return r;
    endfunction

endpackage

>>> rtl/ssr_front.sv
// ----------------------------------------------------------------------------
// ssr_front: request classifier
// Decodes the request code, checks the location index against the table
// depth and rewrites each request into a command for the ramp engine.
// ----------------------------------------------------------------------------
module ssr_front #(
    parameter int NUM_LOCATIONS = ssr_pkg::NUM_LOCATIONS_DEF
) (
    input  ssr_pkg::req_t req,
    output ssr_pkg::cmd_t cmd
);

    logic loc_ok;

    // Check the index against the table depth
    assign loc_ok = (32'(req.loc_index) < 32'(NUM_LOCATIONS));

    // Classify the request
    always_comb
    begin
        cmd.op    = ssr_pkg::OP_NOP;
        cmd.loc   = req.loc_index;
        cmd.width = req.width_value;
        unique case (req.req_type)
            ssr_pkg::REQ_TICK:
            begin
                cmd.op = ssr_pkg::OP_TICK;
            end
            ssr_pkg::REQ_GO_LOC:
            begin
                // an index beyond the table asks for width zero
                if (loc_ok)
                begin
                    cmd.op = ssr_pkg::OP_GO_LOC;
                end
                else
                begin
                    cmd.op    = ssr_pkg::OP_GO_WIDTH;
                    cmd.width = '0;
                end
            end
            ssr_pkg::REQ_GO_WIDTH:
            begin
                cmd.op = ssr_pkg::OP_GO_WIDTH;
            end
            ssr_pkg::REQ_SAVE:
            begin
                cmd.op = loc_ok ? ssr_pkg::OP_SAVE : ssr_pkg::OP_NOP;
            end
            ssr_pkg::REQ_WRITE:
            begin
                cmd.op = loc_ok ? ssr_pkg::OP_WRITE : ssr_pkg::OP_NOP;
            end
            ssr_pkg::REQ_HOME:
            begin
                cmd.op = ssr_pkg::OP_HOME;
            end
            default:
            begin
                cmd.op = ssr_pkg::OP_NOP;
            end
        endcase
    end

endmodule

>>> rtl/ssr_queue.sv
// ----------------------------------------------------------------------------
// ssr_queue: command queue
// Short first-in first-out buffer between the classifier and the ramp
// engine so either side can stall on its own.
// ----------------------------------------------------------------------------
module ssr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ssr_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ssr_pkg::cmd_t pop_cmd
);

    localparam int DEPTH = ssr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ssr_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/ssr_engine.sv
// ----------------------------------------------------------------------------
// ssr_engine: ramp engine
// Executes one command per cycle while the response is not stalled, against
// the ramp state and location table; holds the result in an output register.
// ----------------------------------------------------------------------------
module ssr_engine #(
    parameter int NUM_LOCATIONS = ssr_pkg::NUM_LOCATIONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [ssr_pkg::STEP_W-1:0]         step_size,
    input  logic [ssr_pkg::INTERVAL_W-1:0]     tick_interval,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  ssr_pkg::cmd_t                      cmd,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output ssr_pkg::rsp_t                      rsp
);

    localparam int W     = ssr_pkg::WIDTH_W;
    localparam int SW    = ssr_pkg::SSTEP_W;
    localparam int IDX_W = (NUM_LOCATIONS > 1) ? $clog2(NUM_LOCATIONS) : 1;

    logic [W-1:0]                     out_reg, out_next;
    logic [W-1:0]                     goal_reg, goal_next;
    logic [W-1:0]                     rest_reg, rest_next;
    logic signed [SW-1:0]             sstep_reg, sstep_next;
    logic                             busy_reg, busy_next;
    logic [ssr_pkg::INTERVAL_W-1:0]   elapsed_reg, elapsed_next;
    logic [W-1:0]                     table_reg [NUM_LOCATIONS];
    ssr_pkg::rsp_t                    rsp_reg, rsp_next;
    logic                             rsp_valid_reg;

    logic                             take;
    logic [IDX_W-1:0]                 idx;
    logic [ssr_pkg::STEP_W-1:0]       eff;
    logic [W-1:0]                     eff_w;
    logic [W-1:0]                     go_goal;
    logic [W:0]                       go_delta;
    logic [W-1:0]                     dist_mag;
    logic                             go_refuse;
    logic [W-1:0]                     go_out;
    logic [W-1:0]                     stepped;
    logic [W:0]                       diff;
    logic [W-1:0]                     diff_mag;
    logic [W-1:0]                     home_w;
    logic                             refused;
    logic                             tbl_we;
    logic [W-1:0]                     tbl_wdata;

    assign take      = cmd_valid && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign idx       = IDX_W'(cmd.loc);
    assign eff       = ssr_pkg::eff_step(step_size);
    assign eff_w     = W'(eff);

    // Measure a go request against the settled position
    assign go_goal   = (cmd.op == ssr_pkg::OP_GO_LOC) ? table_reg[idx] : cmd.width;
    assign go_delta  = {1'b0, go_goal} - {1'b0, rest_reg};
    assign dist_mag  = go_delta[W] ? W'(-go_delta) : go_delta[W-1:0];
    assign go_refuse = (dist_mag == '0) || (dist_mag < eff_w) || (dist_mag < ssr_pkg::DEADBAND);
    assign go_out    = go_delta[W] ? rest_reg - eff_w : rest_reg + eff_w;

    // Take one ramp step and measure what is left
    assign stepped  = out_reg + {{(W - SW){sstep_reg[SW-1]}}, sstep_reg};
    assign diff     = {1'b0, stepped} - {1'b0, goal_reg};
    assign diff_mag = diff[W] ? W'(-diff) : diff[W-1:0];

    // Pick the home width
    assign home_w = (table_reg[0] < ssr_pkg::HOME_LOW || table_reg[0] > ssr_pkg::HOME_HIGH)
                  ? ssr_pkg::HOME_DEFAULT : table_reg[0];

    // Execute the command
    always_comb
    begin
        out_next     = out_reg;
        goal_next    = goal_reg;
        rest_next    = rest_reg;
        sstep_next   = sstep_reg;
        busy_next    = busy_reg;
        elapsed_next = elapsed_reg;
        refused      = 1'b0;
        tbl_we       = 1'b0;
        tbl_wdata    = cmd.width;
        unique case (cmd.op) inside
            ssr_pkg::OP_TICK:
            begin
                if (busy_reg)
                begin
                    if (elapsed_reg < tick_interval)
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                    else
                    begin
                        elapsed_next = '0;
                        out_next     = stepped;
                        if (diff_mag <= eff_w)
                        begin
                            out_next  = goal_reg;
                            rest_next = goal_reg;
                            busy_next = 1'b0;
                        end
                    end
                end
            end
            ssr_pkg::OP_GO_LOC, ssr_pkg::OP_GO_WIDTH:
            begin
                goal_next = go_goal;
                if (go_refuse)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    sstep_next   = go_delta[W] ? -SW'(eff) : SW'(eff);
                    out_next     = go_out;
                    busy_next    = 1'b1;
                    elapsed_next = '0;
                end
            end
            ssr_pkg::OP_SAVE:
            begin
                tbl_we    = 1'b1;
                tbl_wdata = rest_reg;
            end
            ssr_pkg::OP_WRITE:
            begin
                tbl_we = 1'b1;
            end
            ssr_pkg::OP_HOME:
            begin
                goal_next    = home_w;
                out_next     = home_w;
                sstep_next   = SW'(eff);
                busy_next    = 1'b1;
                elapsed_next = '0;
            end
            default:
            begin
                refused = 1'b0;
            end
        endcase
        rsp_next.drive_width      = out_next;
        rsp_next.settled_position = rest_next;
        rsp_next.moving           = busy_next;
        rsp_next.refused          = refused;
    end

    // Hold ramp state and table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg       <= '0;
            goal_reg      <= '0;
            rest_reg      <= '0;
            sstep_reg     <= '0;
            busy_reg      <= 1'b0;
            elapsed_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LOCATIONS; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                out_reg     <= out_next;
                goal_reg    <= goal_next;
                rest_reg    <= rest_next;
                sstep_reg   <= sstep_next;
                busy_reg    <= busy_next;
                elapsed_reg <= elapsed_next;
                if (tbl_we)
                begin
                    table_reg[idx] <= tbl_wdata;
                end
            end
            if (take)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

>>> rtl/servo_slew_ramp.sv
// ----------------------------------------------------------------------------
// servo_slew_ramp: servo pulse-width slew-rate limiter
// Front classifier, command queue and ramp engine, with an APB-style
// register port for step size and tick interval.
// ----------------------------------------------------------------------------
// Path: an accepted request is written into the queue; the engine then takes
// it and loads the result register when that register is free or being read.
// Throughput: one request per cycle while the response side does not stall.
// Reset: ramp state and location table clear to zero, step size 5,
// tick interval 4; the queue is empty and ready for requests out of reset.
module servo_slew_ramp #(
    parameter int NUM_LOCATIONS = ssr_pkg::NUM_LOCATIONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  ssr_pkg::req_t                   req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output ssr_pkg::rsp_t                   rsp_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ssr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ssr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ssr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic [ssr_pkg::STEP_W-1:0]     step_reg;
    logic [ssr_pkg::INTERVAL_W-1:0] interval_reg;
    logic                           cfg_we;
    logic                           cfg_idx;
    ssr_pkg::cmd_t                  front_cmd;
    ssr_pkg::cmd_t                  queue_cmd;
    logic                           queue_valid;
    logic                           engine_ready;

    // Register port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_we  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            ssr_pkg::CFG_STEP_SIZE:     prdata = ssr_pkg::APB_DATA_W'(step_reg);
            ssr_pkg::CFG_TICK_INTERVAL: prdata = ssr_pkg::APB_DATA_W'(interval_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= ssr_pkg::STEP_RESET;
            interval_reg <= ssr_pkg::INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == ssr_pkg::CFG_STEP_SIZE)
            begin
                step_reg <= pwdata[ssr_pkg::STEP_W-1:0];
            end
            else
            begin
                interval_reg <= pwdata[ssr_pkg::INTERVAL_W-1:0];
            end
        end
    end

    // Classify the request
    ssr_front #(
        .NUM_LOCATIONS (NUM_LOCATIONS)
    ) u_front (
        .req (req_data),
        .cmd (front_cmd)
    );

    // Buffer commands
    ssr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req_valid),
        .push_ready (req_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (engine_ready),
        .pop_cmd    (queue_cmd)
    );

    // Run the ramp
    ssr_engine #(
        .NUM_LOCATIONS (NUM_LOCATIONS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_size     (step_reg),
        .tick_interval (interval_reg),
        .cmd_valid     (queue_valid),
        .cmd_ready     (engine_ready),
        .cmd           (queue_cmd),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp_data)
    );

endmodule

>>> tb/servo_slew_ramp_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_slew_ramp_chk: response checker for the servo slew ramp
// Watches the request, response and register channels, runs its own copy of
// the ramp engine on every accepted request and compares each accepted
// response, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module servo_slew_ramp_chk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_ready,
    input  ssr_pkg::req_t                   req_data,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  ssr_pkg::rsp_t                   rsp_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ssr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ssr_pkg::APB_DATA_W-1:0]  pwdata,
    input  logic                            pready,
    output int                              fail_count,
    output int                              pending
);
    import ssr_pkg::*;

    localparam int NUM_LOCATIONS = NUM_LOCATIONS_DEF;
    localparam int MAX_PRINTED   = 100;

    // Register copies
    logic [STEP_W-1:0]     step_cfg;
    logic [INTERVAL_W-1:0] interval_cfg;

    // Ramp engine copy
    logic [WIDTH_W-1:0]    out_w;
    logic [WIDTH_W-1:0]    goal_w;
    logic [WIDTH_W-1:0]    rest_w;
    int                    ramp_dir_step;
    logic                  ramping;
    logic [INTERVAL_W-1:0] tick_count;
    logic [WIDTH_W-1:0]    loc_table [NUM_LOCATIONS];

    // Predicted responses, oldest first
    rsp_t                  servo_rsp_q [$];

    // Step size actually used: out-of-range settings fall back
    function automatic int active_step();
        if (step_cfg < STEP_MIN || step_cfg > STEP_MAX)
        begin
            return int'(STEP_FALLBACK);
        end
        return int'(step_cfg);
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
        begin
            $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
        end
    endtask

    // Start a move toward target, measured from the settled position
    task automatic begin_move(input logic [WIDTH_W-1:0] target, output logic refused);
        int st;
        int delta;
        st      = active_step();
        goal_w  = target;
        delta   = int'(target) - int'(rest_w);
        refused = 1'b0;
        if (delta == 0 || magnitude(delta) < st || magnitude(delta) < int'(DEADBAND))
        begin
            refused = 1'b1;
        end
        else
        begin
            ramp_dir_step = (delta < 0) ? -st : st;
            out_w         = WIDTH_W'(int'(rest_w) + ramp_dir_step);
            ramping       = 1'b1;
            tick_count    = '0;
        end
    endtask

    // Advance the engine copy by one request and form its response
    task automatic servo_apply(input req_t r, output rsp_t resp);
        int                 st;
        logic [WIDTH_W-1:0] home_w;
        logic               refused;
        st      = active_step();
        refused = 1'b0;
        case (r.req_type)
            REQ_TICK:
            begin
                if (ramping)
                begin
                    if (tick_count < interval_cfg)
                    begin
                        tick_count = tick_count + 1'b1;
                    end
                    else
                    begin
                        tick_count = '0;
                        out_w      = WIDTH_W'(int'(out_w) + ramp_dir_step);
                        // Snap to the goal once within one step
                        if (magnitude(int'(out_w) - int'(goal_w)) <= st)
                        begin
                            out_w   = goal_w;
                            rest_w  = goal_w;
                            ramping = 1'b0;
                        end
                    end
                end
            end
            REQ_GO_LOC:
            begin
                if (int'(r.loc_index) < NUM_LOCATIONS)
                begin
                    begin_move(loc_table[r.loc_index], refused);
                end
                else
                begin
                    begin_move('0, refused);
                end
            end
            REQ_GO_WIDTH:
            begin
                begin_move(r.width_value, refused);
            end
            REQ_SAVE:
            begin
                if (int'(r.loc_index) < NUM_LOCATIONS)
                begin
                    loc_table[r.loc_index] = rest_w;
                end
            end
            REQ_WRITE:
            begin
                if (int'(r.loc_index) < NUM_LOCATIONS)
                begin
                    loc_table[r.loc_index] = r.width_value;
                end
            end
            REQ_HOME:
            begin
                home_w = loc_table[0];
                if (home_w < HOME_LOW || home_w > HOME_HIGH)
                begin
                    home_w = HOME_DEFAULT;
                end
                goal_w        = home_w;
                out_w         = home_w;
                ramp_dir_step = st;
                ramping       = 1'b1;
                tick_count    = '0;
            end
            default:
            begin
            end
        endcase
        resp.drive_width      = out_w;
        resp.settled_position = rest_w;
        resp.moving           = ramping;
        resp.refused          = refused;
    endtask

    // Track register writes, check responses, predict on requests
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t got;
        if (!rst_n)
        begin
            step_cfg      = STEP_RESET;
            interval_cfg  = INTERVAL_RESET;
            out_w         = '0;
            goal_w        = '0;
            rest_w        = '0;
            ramp_dir_step = 0;
            ramping       = 1'b0;
            tick_count    = '0;
            for (int i = 0; i < NUM_LOCATIONS; i++)
            begin
                loc_table[i] = '0;
            end
            servo_rsp_q.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                if (paddr[2] == CFG_STEP_SIZE)
                begin
                    step_cfg = pwdata[STEP_W-1:0];
                end
                else
                begin
                    interval_cfg = pwdata[INTERVAL_W-1:0];
                end
            end

            if (rsp_valid && rsp_ready)
            begin
                got = rsp_data;
                if (servo_rsp_q.size() == 0)
                begin
                    report_mismatch("response with no request outstanding",
                                    int'(got.drive_width), -1);
                end
                else
                begin
                    want = servo_rsp_q.pop_front();
                    if (got.drive_width !== want.drive_width)
                    begin
                        report_mismatch("drive_width", int'(got.drive_width),
                                        int'(want.drive_width));
                    end
                    if (got.settled_position !== want.settled_position)
                    begin
                        report_mismatch("settled_position", int'(got.settled_position),
                                        int'(want.settled_position));
                    end
                    if (got.moving !== want.moving)
                    begin
                        report_mismatch("moving", int'(got.moving), int'(want.moving));
                    end
                    if (got.refused !== want.refused)
                    begin
                        report_mismatch("refused", int'(got.refused), int'(want.refused));
                    end
                end
            end

            if (req_valid && req_ready)
            begin
                servo_apply(req_data, want);
                servo_rsp_q.push_back(want);
            end
            pending = servo_rsp_q.size();
        end
    end

endmodule

>>> tb/servo_slew_ramp_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_slew_ramp_tb: top-level testbench for the servo slew ramp
// Drives a directed set of requests and then long random stretches of moves
// followed by tick runs, under several step and interval settings and three
// idling patterns; the checker beside the block judges every response.
// ----------------------------------------------------------------------------
module servo_slew_ramp_tb;
    import ssr_pkg::*;

    localparam int CLK_HIGH          = 10;
    localparam int CLK_LOW           = 10;
    localparam int RESET_CYCLES      = 12;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int NUM_SEGMENTS      = 6;
    localparam int ITEMS_PER_SEGMENT = 315;
    localparam int DRAIN_CYCLES      = 10;

    // Request codes the block leaves alone
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    // Register settings per segment: extremes and fallback step sizes
    localparam int STEP_PLAN     [NUM_SEGMENTS] = '{12, 2, 0, 7, 15, 9};
    localparam int INTERVAL_PLAN [NUM_SEGMENTS] = '{1, 0, 3, 255, 2, 1};

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_t                   req_data  = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    rsp_t                   rsp_data;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr     = '0;
    logic [APB_DATA_W-1:0]  pwdata    = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int                     send_idle_pct = 22;
    int                     recv_idle_pct = 61;
    int                     sent_count    = 0;
    int                     cycle_count   = 0;
    int                     fail_count;
    int                     pending;
    logic [WIDTH_W-1:0]     last_goal     = '0;

    servo_slew_ramp i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    servo_slew_ramp_chk i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #CLK_HIGH;
        clk = 1'b0;
        #CLK_LOW;
    end

    // Stall the response side at random
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Present one request, idling first at random, and hold it until taken
    task automatic send_req(input logic [2:0] code, input logic [2:0] loc,
                            input logic [WIDTH_W-1:0] width);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_data.req_type    = code;
        req_data.loc_index   = loc;
        req_data.width_value = width;
        req_valid            = 1'b1;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        if (code <= REQ_HOME)
        begin
            sent_count++;
        end
    endtask

    // Drop valid and hold off until every response is back
    task automatic hold_until_drained();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Register write: setup phase, then access phase until pready
    task automatic write_reg(input logic sel, input int value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({sel, 2'b00});
        pwdata  = APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Goal widths: anywhere, close to the last goal, or near either end
    function automatic logic [WIDTH_W-1:0] pick_goal(input logic [WIDTH_W-1:0] prev);
        case ($urandom_range(0, 3))
            0:       return WIDTH_W'($urandom);
            1, 2:    return prev + WIDTH_W'($urandom_range(0, 40)) - WIDTH_W'(20);
            default: return ($urandom_range(0, 1) != 0) ? WIDTH_W'($urandom_range(0, 31))
                                                       : WIDTH_W'($urandom_range(4064, 4095));
        endcase
    endfunction

    // Refusals, restart while moving, home clamping, spare codes
    task automatic run_directed();
        send_req(REQ_TICK, 3'd0, 12'd0);
        send_req(REQ_GO_WIDTH, 3'd0, 12'd0);
        send_req(REQ_GO_WIDTH, 3'd0, 12'd4);
        send_req(REQ_GO_WIDTH, 3'd0, 12'd7);
        send_req(REQ_GO_WIDTH, 3'd7, 12'd4095);
        send_req(REQ_GO_WIDTH, 3'd0, 12'd40);
        for (int i = 0; i < 5; i++)
        begin
            send_req(REQ_TICK, 3'd0, 12'd0);
        end
        send_req(REQ_SAVE, 3'd3, 12'd0);
        send_req(REQ_WRITE, 3'd0, 12'd4095);
        send_req(REQ_HOME, 3'd0, 12'd0);
        send_req(REQ_WRITE, 3'd0, 12'd900);
        send_req(REQ_HOME, 3'd0, 12'd0);
        send_req(REQ_WRITE, 3'd0, 12'd2100);
        send_req(REQ_HOME, 3'd7, 12'd4095);
        send_req(REQ_WRITE, 3'd0, 12'd2101);
        send_req(REQ_HOME, 3'd0, 12'd0);
        send_req(REQ_WRITE, 3'd0, 12'd899);
        send_req(REQ_HOME, 3'd0, 12'd0);
        send_req(REQ_GO_LOC, 3'd3, 12'd0);
        send_req(REQ_SPARE_A, 3'd7, 12'd4095);
        send_req(REQ_SPARE_B, 3'd0, 12'd0);
    endtask

    // One random stretch: mostly a move and a tick run, sometimes noise
    task automatic random_burst();
        int                 run_len;
        logic [2:0]         idx;
        logic [WIDTH_W-1:0] target;
        if ($urandom_range(0, 99) < 70)
        begin
            idx = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    target    = pick_goal(last_goal);
                    last_goal = target;
                    send_req(REQ_GO_WIDTH, idx, target);
                end
                6, 7:    send_req(REQ_GO_LOC, idx, WIDTH_W'($urandom));
                8:       send_req(REQ_HOME, idx, WIDTH_W'($urandom));
                default:
                begin
                    target    = pick_goal(last_goal);
                    last_goal = target;
                    send_req(REQ_WRITE, idx, target);
                    send_req(REQ_GO_LOC, idx, WIDTH_W'($urandom));
                end
            endcase
            run_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 30)
                                                   : $urandom_range(40, 250);
            // Cut the tick run short once the segment has its requests
            for (int i = 0; i < run_len && sent_count < ITEMS_PER_SEGMENT; i++)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    send_req(REQ_SAVE, 3'($urandom), WIDTH_W'($urandom));
                end
                else
                begin
                    send_req(REQ_TICK, 3'($urandom), WIDTH_W'($urandom));
                end
            end
        end
        else
        begin
            send_req(3'($urandom), 3'($urandom), WIDTH_W'($urandom));
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            if (seg == 2)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 22;
            end
            else if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            hold_until_drained();
            write_reg(CFG_STEP_SIZE, STEP_PLAN[seg]);
            write_reg(CFG_TICK_INTERVAL, INTERVAL_PLAN[seg]);
            sent_count = 0;
            while (sent_count < ITEMS_PER_SEGMENT)
            begin
                random_burst();
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
